// ----- hdl/lzp_match_decoder_macros.svh -----
// assertion helpers used by the decoder datapath
`ifndef LZP_MATCH_DECODER_MACROS_SVH
`define LZP_MATCH_DECODER_MACROS_SVH

// same-cycle implication under reset
`define LZP_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define LZP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lzp_pkg.sv -----
// ----------------------------------------------------------------------------
// lzp_pkg
// shared constants, command codes and status struct of the lzp match decoder
// ----------------------------------------------------------------------------
package lzp_pkg;

    localparam int HISTORY_BYTES_DEF = 65536;
    localparam int MAX_HASH_BITS_DEF = 16;
    localparam int BURST_BYTES_DEF   = 64;

    localparam logic [7:0] MATCH_FLAG = 8'hF2;
    localparam logic [7:0] CODE_ESC   = 8'd255;
    localparam logic [7:0] CODE_MORE  = 8'd254;

    localparam logic CFG_HASH_BITS = 1'b0;
    localparam logic CFG_MIN_LEN   = 1'b1;

    localparam logic [4:0] HASH_BITS_RST = 5'd16;
    localparam logic [7:0] MIN_LEN_RST   = 8'd128;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_FLAG   = 2'd1;
    localparam logic [1:0] MODE_LENGTH = 2'd2;
    localparam logic [1:0] MODE_COPY   = 2'd3;

    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NONE  = 4'd0;
    localparam t_cmd CMD_LATCH = 4'd1;
    localparam t_cmd CMD_CLR   = 4'd2;
    localparam t_cmd CMD_MARK  = 4'd3;
    localparam t_cmd CMD_ESC   = 4'd4;
    localparam t_cmd CMD_LEN1  = 4'd5;
    localparam t_cmd CMD_LENN  = 4'd6;
    localparam t_cmd CMD_START = 4'd7;
    localparam t_cmd CMD_HRD   = 4'd8;
    localparam t_cmd CMD_PUTC  = 4'd9;
    localparam t_cmd CMD_PUTL  = 4'd10;
    localparam t_cmd CMD_TRD   = 4'd11;
    localparam t_cmd CMD_TLOOK = 4'd12;

    typedef struct packed {
        logic [1:0] mode;
        logic       func;
        logic       byte_esc;
        logic       byte_more;
        logic       pos_full;
        logic       pos_lt4;
        logic       rem_zero;
        logic       hit;
        logic       copy_last;
        logic       clr_done;
        logic       out_free;
    } t_status;

endpackage

// ----- hdl/lzp_match_decoder.sv -----
// ----------------------------------------------------------------------------
// lzp_match_decoder
// lzp stream decoder: one compressed byte per input transfer, decoded bytes out
//
//   channel   dir  tdata        tuser                        tlast
//   s_axis    in   code_byte    [0] func, [1] block_start    -
//   m_axis    out  out_byte     [0] copy_pending, [1] overflow  run_last
//   cfg       in   i_cfg_wdata  i_cfg_idx 0 hash_bits, 1 min_len
//
// a literal is dispatched and then put, with a table read and lookup between
// them once four bytes are out; a copied byte takes a history read, then write
// and emit, up to BURST_BYTES per item. after reset and after every block_start
// the position table is cleared, one entry per cycle, with s_axis_tready low.
// a stalled m_axis holds the sequencer only when a new result is ready.
// ----------------------------------------------------------------------------
module lzp_match_decoder #(
    parameter int HISTORY_BYTES = lzp_pkg::HISTORY_BYTES_DEF,
    parameter int MAX_HASH_BITS = lzp_pkg::MAX_HASH_BITS_DEF,
    parameter int BURST_BYTES   = lzp_pkg::BURST_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // code_byte
    input  logic [1:0] s_axis_tuser,   // func, block_start
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic [1:0] m_axis_tuser,   // copy_pending, overflow
    output logic       m_axis_tlast
);
    import lzp_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    lzp_ctl u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_block_start (s_axis_tuser[1]),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    lzp_dp #(
        .HISTORY_BYTES (HISTORY_BYTES),
        .MAX_HASH_BITS (MAX_HASH_BITS),
        .BURST_BYTES   (BURST_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_code_byte    (s_axis_tdata),
        .i_func         (s_axis_tuser[0]),
        .i_block_start  (s_axis_tuser[1]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_byte     (m_axis_tdata),
        .o_run_last     (m_axis_tlast),
        .o_copy_pending (m_axis_tuser[0]),
        .o_overflow     (m_axis_tuser[1]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready)
    );

endmodule

// ----- hdl/lzp_ctl.sv -----
// ----------------------------------------------------------------------------
// lzp_ctl
// sequencer of the decoder: walks each item through clear, parse, lookup and copy
// ----------------------------------------------------------------------------
module lzp_ctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic            i_block_start,
    input  lzp_pkg::t_status i_sts,
    output lzp_pkg::t_cmd   o_cmd
);
    import lzp_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DISP  = 4'd2;
    localparam logic [3:0] ST_START = 4'd3;
    localparam logic [3:0] ST_RD    = 4'd4;
    localparam logic [3:0] ST_PUTC  = 4'd5;
    localparam logic [3:0] ST_HASH  = 4'd6;
    localparam logic [3:0] ST_LOOK  = 4'd7;
    localparam logic [3:0] ST_PUTL  = 4'd8;
    localparam logic [3:0] ST_ESC   = 4'd9;
    localparam logic [3:0] ST_MARK  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_have, n_have;

    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_have  = r_have;
        o_cmd   = CMD_NONE;
        case (r_state)
            ST_CLEAR: begin
                o_cmd = CMD_CLR;
                if (i_sts.clr_done) begin
                    n_state = r_have ? ST_DISP : ST_IDLE;
                    n_have  = 1'b0;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd = CMD_LATCH;
                    if (i_block_start) begin
                        n_state = ST_CLEAR;
                        n_have  = 1'b1;
                    end else begin
                        n_state = ST_DISP;
                    end
                end
            end
            ST_DISP: begin
                if (i_sts.pos_full) begin
                    n_state = ST_MARK;
                end else if (i_sts.mode == MODE_COPY) begin
                    n_state = ST_START;
                end else if (i_sts.func) begin
                    n_state = ST_IDLE;
                end else if (i_sts.mode == MODE_FLAG) begin
                    if (i_sts.byte_esc) begin
                        n_state = ST_ESC;
                    end else begin
                        o_cmd   = CMD_LEN1;
                        n_state = i_sts.byte_more ? ST_IDLE : ST_START;
                    end
                end else if (i_sts.mode == MODE_LENGTH) begin
                    o_cmd   = CMD_LENN;
                    n_state = i_sts.byte_more ? ST_IDLE : ST_START;
                end else if (i_sts.pos_lt4) begin
                    n_state = ST_PUTL;
                end else begin
                    n_state = ST_HASH;
                end
            end
            ST_START: begin
                o_cmd   = CMD_START;
                n_state = i_sts.rem_zero ? ST_IDLE : ST_RD;
            end
            ST_RD: begin
                o_cmd   = CMD_HRD;
                n_state = ST_PUTC;
            end
            ST_PUTC: begin
                if (i_sts.out_free) begin
                    o_cmd   = CMD_PUTC;
                    n_state = i_sts.copy_last ? ST_IDLE : ST_RD;
                end
            end
            ST_HASH: begin
                o_cmd   = CMD_TRD;
                n_state = ST_LOOK;
            end
            ST_LOOK: begin
                o_cmd   = CMD_TLOOK;
                n_state = i_sts.hit ? ST_IDLE : ST_PUTL;
            end
            ST_PUTL: begin
                if (i_sts.out_free) begin
                    o_cmd   = CMD_PUTL;
                    n_state = ST_IDLE;
                end
            end
            ST_ESC: begin
                if (i_sts.out_free) begin
                    o_cmd   = CMD_ESC;
                    n_state = ST_IDLE;
                end
            end
            ST_MARK: begin
                if (i_sts.out_free) begin
                    o_cmd   = CMD_MARK;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_have  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
        end
    end

endmodule

// ----- hdl/lzp_dp.sv -----
// ----------------------------------------------------------------------------
// lzp_dp
// decoder datapath: history and position memories, context, copy counters,
// configuration and the result register
// ----------------------------------------------------------------------------
`include "lzp_match_decoder_macros.svh"

module lzp_dp #(
    parameter int HISTORY_BYTES = lzp_pkg::HISTORY_BYTES_DEF,
    parameter int MAX_HASH_BITS = lzp_pkg::MAX_HASH_BITS_DEF,
    parameter int BURST_BYTES   = lzp_pkg::BURST_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_wdata,
    input  logic [7:0]       i_code_byte,
    input  logic             i_func,
    input  logic             i_block_start,
    input  lzp_pkg::t_cmd    i_cmd,
    output lzp_pkg::t_status o_sts,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_copy_pending,
    output logic             o_overflow,
    output logic             o_out_valid,
    input  logic             i_out_ready
);
    import lzp_pkg::*;

    localparam int AW = $clog2(HISTORY_BYTES);
    localparam int PW = $clog2(HISTORY_BYTES + 1);
    localparam int HB = MAX_HASH_BITS;
    localparam int BW = $clog2(BURST_BYTES + 1);
    localparam int TD = 1 << HB;
    localparam logic [PW:0]   HMAX   = (PW + 1)'(HISTORY_BYTES);
    localparam logic [PW:0]   BMAX   = (PW + 1)'(BURST_BYTES);
    localparam logic [BW-1:0] BLAST  = BW'(BURST_BYTES - 1);
    localparam logic [4:0]    HB5    = 5'(HB);

    logic [7:0]    r_hist [HISTORY_BYTES];
    logic [AW-1:0] r_tab  [TD];

    logic [4:0]    r_cfg_hb;
    logic [7:0]    r_cfg_min;
    logic          r_func;
    logic [7:0]    r_byte;
    logic [31:0]   r_ctx;
    logic [PW-1:0] r_pos;
    logic [1:0]    r_mode;
    logic [AW-1:0] r_src;
    logic [PW-1:0] r_rem;
    logic [BW-1:0] r_cnt;
    logic          r_pend;
    logic [HB-1:0] r_idx;
    logic [HB-1:0] r_clr;
    logic [7:0]    r_hrd;
    logic [AW-1:0] r_trd;
    logic          r_ovalid;

    logic          w_put;
    logic          w_full;
    logic [7:0]    w_pbyte;
    logic [PW:0]   w_add_a;
    logic [PW:0]   w_sum;
    logic [PW-1:0] w_sat;
    logic [4:0]    w_hb;
    logic [HB-1:0] w_mask;
    logic [31:0]   w_hmix;
    logic [HB-1:0] w_hash;
    logic          w_copy_last;
    logic          w_start_pend;
    logic          w_tab_we;
    logic [HB-1:0] w_tab_addr;
    logic [AW-1:0] w_tab_wd;

    assign w_full  = ({1'b0, r_pos} >= HMAX);
    assign w_put   = (i_cmd == CMD_PUTC) || (i_cmd == CMD_PUTL) || (i_cmd == CMD_ESC);
    assign w_pbyte = (i_cmd == CMD_PUTC) ? r_hrd : ((i_cmd == CMD_ESC) ? MATCH_FLAG : r_byte);

    assign w_add_a = (i_cmd == CMD_LEN1) ? (PW + 1)'(r_cfg_min) : {1'b0, r_rem};
    assign w_sum   = w_add_a + (PW + 1)'(r_byte);
    assign w_sat   = (w_sum > HMAX) ? HMAX[PW-1:0] : w_sum[PW-1:0];

    assign w_hb   = (r_cfg_hb > HB5) ? HB5 : r_cfg_hb;
    assign w_mask = ~({HB{1'b1}} << w_hb);
    assign w_hmix = (r_ctx >> 15) ^ r_ctx ^ (r_ctx >> 3);
    assign w_hash = w_hmix[HB-1:0] & w_mask;

    assign w_copy_last  = (r_rem == PW'(1)) || (r_cnt == BLAST);
    assign w_start_pend = ({1'b0, r_rem} > BMAX) && (({1'b0, r_pos} + BMAX) <= HMAX);

    assign o_sts.mode      = r_mode;
    assign o_sts.func      = r_func;
    assign o_sts.byte_esc  = (r_byte == CODE_ESC);
    assign o_sts.byte_more = (r_byte == CODE_MORE);
    assign o_sts.pos_full  = w_full;
    assign o_sts.pos_lt4   = (r_pos < PW'(4));
    assign o_sts.rem_zero  = (r_rem == '0);
    assign o_sts.hit       = (r_byte == MATCH_FLAG) && (r_trd != '0);
    assign o_sts.copy_last = w_full || w_copy_last;
    assign o_sts.clr_done  = &r_clr;
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;

    // history store
    always_ff @(posedge i_clk) begin
        if (w_put && !w_full) begin
            r_hist[r_pos[AW-1:0]] <= w_pbyte;
        end
        if (i_cmd == CMD_HRD) begin
            r_hrd <= r_hist[r_src];
        end
    end

    // position table
    assign w_tab_we   = (i_cmd == CMD_CLR) || (i_cmd == CMD_TLOOK);
    assign w_tab_addr = (i_cmd == CMD_CLR) ? r_clr : r_idx;
    assign w_tab_wd   = (i_cmd == CMD_CLR) ? '0 : r_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_tab[w_tab_addr] <= w_tab_wd;
        end
        if (i_cmd == CMD_TRD) begin
            r_trd <= r_tab[w_hash];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_TRD) begin
            r_idx <= w_hash;
        end
        if (i_cmd == CMD_LATCH) begin
            r_func <= i_func;
            r_byte <= i_code_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hb  <= HASH_BITS_RST;
            r_cfg_min <= MIN_LEN_RST;
            r_ctx     <= '0;
            r_pos     <= '0;
            r_mode    <= MODE_NORMAL;
            r_src     <= '0;
            r_rem     <= '0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_clr     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HASH_BITS) begin
                    r_cfg_hb <= i_cfg_wdata[4:0];
                end else begin
                    r_cfg_min <= i_cfg_wdata;
                end
            end
            if (r_ovalid && i_out_ready && !w_put && (i_cmd != CMD_MARK)) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd)
                CMD_LATCH: begin
                    if (i_block_start) begin
                        r_ctx  <= '0;
                        r_pos  <= '0;
                        r_mode <= MODE_NORMAL;
                        r_src  <= '0;
                        r_rem  <= '0;
                        r_clr  <= '0;
                    end
                end
                CMD_CLR: begin
                    r_clr <= r_clr + HB'(1);
                end
                CMD_MARK: begin
                    r_ovalid       <= 1'b1;
                    o_out_byte     <= '0;
                    o_run_last     <= 1'b1;
                    o_copy_pending <= (r_mode == MODE_COPY) && (r_rem != '0);
                    o_overflow     <= 1'b1;
                end
                CMD_LEN1, CMD_LENN: begin
                    r_rem  <= w_sat;
                    r_mode <= (r_byte == CODE_MORE) ? MODE_LENGTH : MODE_COPY;
                end
                CMD_START: begin
                    r_cnt  <= '0;
                    r_pend <= w_start_pend;
                    if (r_rem == '0) begin
                        r_mode <= MODE_NORMAL;
                    end
                end
                CMD_TLOOK: begin
                    if (o_sts.hit) begin
                        r_mode <= MODE_FLAG;
                        r_src  <= r_trd;
                    end
                end
                CMD_ESC, CMD_PUTL, CMD_PUTC: begin
                    r_ovalid <= 1'b1;
                    if (w_full) begin
                        r_rem          <= '0;
                        r_mode         <= MODE_NORMAL;
                        o_out_byte     <= '0;
                        o_run_last     <= 1'b1;
                        o_copy_pending <= 1'b0;
                        o_overflow     <= 1'b1;
                    end else begin
                        r_pos      <= r_pos + PW'(1);
                        r_ctx      <= {r_ctx[23:0], w_pbyte};
                        o_out_byte <= w_pbyte;
                        o_overflow <= 1'b0;
                        if (i_cmd == CMD_PUTC) begin
                            r_src          <= r_src + AW'(1);
                            r_rem          <= r_rem - PW'(1);
                            r_cnt          <= r_cnt + BW'(1);
                            o_run_last     <= w_copy_last;
                            o_copy_pending <= r_pend;
                            if (r_rem == PW'(1)) begin
                                r_mode <= MODE_NORMAL;
                            end
                        end else begin
                            o_run_last     <= 1'b1;
                            o_copy_pending <= 1'b0;
                            if (i_cmd == CMD_ESC) begin
                                r_mode <= MODE_NORMAL;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `LZP_ASSERT(a_pos_range, 1'b1, {1'b0, r_pos} <= HMAX, "output position past history size")
    `LZP_ASSERT(a_burst_cnt, 1'b1, r_cnt <= BW'(BURST_BYTES), "burst count out of range")
    `LZP_ASSERT(a_marker_last, r_ovalid && o_overflow,
        o_run_last && (o_out_byte == '0), "bad overflow marker")
    `LZP_ASSERT_NEXT(a_block_clear, (i_cmd == CMD_LATCH) && i_block_start,
        (r_pos == '0) && (r_rem == '0), "block start left state behind")

endmodule

// ----- sim/tb_lzp_match_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lzp_match_decoder
// self-checking testbench of the lzp match decoder
//
// drives compressed bytes and continue transfers on s_axis with random gaps,
// runs a local decoder model on each accepted transfer and compares every
// m_axis transfer, under random back-pressure, against the predicted bytes.
// covers first-four pass-through, escaped flags, chained length bytes, long
// overlapping copies in bursts, small and zero lengths, hash widths of 0, 10,
// 11 to 15, 16 and 31, and the overflow marker when a block outgrows the history.
// ----------------------------------------------------------------------------
module tb_lzp_match_decoder;
    import lzp_pkg::*;

    localparam int HIST   = HISTORY_BYTES_DEF;
    localparam int BURST  = BURST_BYTES_DEF;
    localparam int MAXHB  = MAX_HASH_BITS_DEF;
    localparam int LIMIT  = 5000000;
    localparam int SETTLE = 300;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       pend;
        logic       ovf;
    } t_dec_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_wdata;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // code_byte
    logic [1:0] s_axis_tuser;   // func, block_start
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // out_byte
    logic [1:0] m_axis_tuser;   // copy_pending, overflow
    logic       m_axis_tlast;

    // decoder model state
    logic [7:0]  hist_mem [HIST];
    int unsigned pos_tab [1 << MAXHB];
    logic [31:0] ctx_word;
    int unsigned out_pos;
    logic [1:0]  mode;
    int unsigned src_pos;
    int unsigned copy_left;
    int unsigned hash_bits;
    int unsigned min_len;

    t_dec_byte   item_bytes [$];
    t_dec_byte   expected_bytes [$];
    int          errors = 0;
    int unsigned cycles = 0;
    bit          src_quiet = 0;
    bit          sink_quiet = 0;
    int          sink_stall = 0;

    always #5 i_clk = ~i_clk;

    lzp_match_decoder u_top (.*);

    function automatic bit emit_byte(logic [7:0] b);
        if (out_pos >= HIST) begin
            out_pos = HIST;
            copy_left = 0;
            mode = MODE_NORMAL;
            item_bytes.push_back('{8'd0, 1'b0, 1'b0, 1'b1});
            return 0;
        end
        hist_mem[out_pos] = b;
        out_pos++;
        ctx_word = {ctx_word[23:0], b};
        item_bytes.push_back('{b, 1'b0, 1'b0, 1'b0});
        return 1;
    endfunction

    function automatic void copy_burst();
        logic [7:0] b;
        while (copy_left > 0 && item_bytes.size() < BURST) begin
            b = hist_mem[src_pos];
            src_pos++;
            copy_left--;
            if (!emit_byte(b)) return;
        end
        if (copy_left == 0) mode = MODE_NORMAL;
    endfunction

    function automatic int unsigned add_len(int unsigned a, int unsigned b);
        return (a + b > HIST) ? HIST : a + b;
    endfunction

    function automatic void decode_item(logic func, logic [7:0] b, logic bs);
        int unsigned hb, idx, hit_pos;
        logic [31:0] h;
        bit pend;
        item_bytes.delete();
        if (bs) begin
            foreach (pos_tab[i]) pos_tab[i] = 0;
            ctx_word = 0;
            out_pos = 0;
            mode = MODE_NORMAL;
            src_pos = 0;
            copy_left = 0;
        end
        if (out_pos >= HIST) begin
            item_bytes.push_back('{8'd0, 1'b0, 1'b0, 1'b1});
        end else if (mode == MODE_COPY) begin
            copy_burst();
        end else if (func == 1'b1) begin
        end else if (mode == MODE_FLAG) begin
            if (b == CODE_ESC) begin
                mode = MODE_NORMAL;
                void'(emit_byte(MATCH_FLAG));
            end else begin
                copy_left = add_len(min_len, 32'(b));
                if (b == CODE_MORE) mode = MODE_LENGTH;
                else begin
                    mode = MODE_COPY;
                    copy_burst();
                end
            end
        end else if (mode == MODE_LENGTH) begin
            copy_left = add_len(copy_left, 32'(b));
            if (b != CODE_MORE) begin
                mode = MODE_COPY;
                copy_burst();
            end
        end else if (out_pos < 4) begin
            void'(emit_byte(b));
        end else begin
            hb = (hash_bits > MAXHB) ? MAXHB : hash_bits;
            h = (ctx_word >> 15) ^ ctx_word ^ (ctx_word >> 3);
            idx = h & ((32'd1 << hb) - 1);
            hit_pos = pos_tab[idx];
            pos_tab[idx] = out_pos;
            if (b == MATCH_FLAG && hit_pos > 0) begin
                mode = MODE_FLAG;
                src_pos = hit_pos;
            end else begin
                void'(emit_byte(b));
            end
        end
        pend = (mode == MODE_COPY && copy_left > 0);
        foreach (item_bytes[i]) begin
            item_bytes[i].pend = pend;
            item_bytes[i].last = (i == item_bytes.size() - 1);
            expected_bytes.push_back(item_bytes[i]);
        end
    endfunction

    task automatic send_item(logic func, logic [7:0] b, logic bs = 1'b0);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {bs, func};
        do @(posedge i_clk); while (!s_axis_tready);
        decode_item(func, b, bs);
        gap = src_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HASH_BITS) hash_bits = 32'(val[4:0]);
        else min_len = 32'(val);
    endtask

    task automatic finish_copy();
        while (mode == MODE_COPY) send_item(1'b1, 8'h00);
    endtask

    task automatic test_directed();
        send_item(1'b0, 8'h41, 1'b1);
        send_item(1'b0, MATCH_FLAG);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        repeat (6) send_item(1'b0, 8'h41);
        send_item(1'b0, MATCH_FLAG);
        send_item(1'b0, CODE_ESC);
        repeat (4) send_item(1'b0, 8'h41);
        send_item(1'b0, MATCH_FLAG);
        send_item(1'b0, CODE_MORE);
        send_item(1'b0, 8'd3);
        send_item(1'b0, 8'hA5);
        finish_copy();
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h42);
        wait_idle();
    endtask

    task automatic test_small_len();
        write_cfg(CFG_HASH_BITS, 8'd0);
        write_cfg(CFG_MIN_LEN, 8'd0);
        send_item(1'b0, 8'h41, 1'b1);
        repeat (6) send_item(1'b0, 8'h41);
        send_item(1'b0, MATCH_FLAG);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'h42);
        send_item(1'b0, MATCH_FLAG);
        send_item(1'b0, 8'd1);
        finish_copy();
        send_item(1'b0, MATCH_FLAG);
        send_item(1'b0, 8'd253);
        finish_copy();
        wait_idle();
    endtask

    task automatic test_random_block(int n);
        int r;
        logic [7:0] b;
        send_item(1'b0, 8'h41, 1'b1);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                src_quiet = ~src_quiet;
                sink_quiet = ($urandom_range(0, 3) == 0);
            end
            case (mode)
                MODE_COPY: begin
                    if (r < 85) send_item(1'b1, 8'($urandom_range(0, 255)));
                    else send_item(1'b0, 8'($urandom_range(0, 255)));
                end
                MODE_FLAG: begin
                    if (r < 30) b = CODE_ESC;
                    else if (r < 45) b = CODE_MORE;
                    else if (r < 55) b = 8'($urandom_range(0, 255));
                    else b = 8'($urandom_range(0, 40));
                    send_item(r[0] && r > 95, b);
                end
                MODE_LENGTH: begin
                    b = (r < 30) ? CODE_MORE : 8'($urandom_range(0, 30));
                    send_item(1'b0, b);
                end
                default: begin
                    if (r < 5) send_item(1'b1, 8'($urandom_range(0, 255)));
                    else if (r < 25) send_item(1'b0, MATCH_FLAG);
                    else if (r < 35) send_item(1'b0, 8'($urandom_range(0, 255)));
                    else send_item(1'b0, 8'h41 + 8'($urandom_range(0, 1)));
                end
            endcase
        end
        finish_copy();
        src_quiet = 0;
        sink_quiet = 0;
        wait_idle();
    endtask

    task automatic test_overflow();
        write_cfg(CFG_MIN_LEN, 8'd255);
        write_cfg(CFG_HASH_BITS, 8'd16);
        src_quiet = 1;
        sink_quiet = 1;
        send_item(1'b0, 8'h41, 1'b1);
        repeat (7) send_item(1'b0, 8'h41);
        send_item(1'b0, MATCH_FLAG);
        repeat (258) send_item(1'b0, CODE_MORE);
        send_item(1'b0, 8'd3);
        finish_copy();
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h41);
        send_item(1'b0, MATCH_FLAG);
        src_quiet = 0;
        sink_quiet = 0;
        wait_idle();
    endtask

    // pause the sender until every queued byte has drained mid-stream
    task automatic test_drain_pause();
        send_item(1'b0, 8'h41, 1'b1);
        repeat (6) send_item(1'b0, 8'h42);
        send_item(1'b0, MATCH_FLAG);
        send_item(1'b0, 8'd100);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        finish_copy();
        repeat (10) send_item(1'b0, 8'($urandom_range(0, 255)));
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output byte %h", m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata !== expected_bytes[0].data) begin
                    $error("out_byte exp %h got %h", expected_bytes[0].data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== expected_bytes[0].last) begin
                    $error("run_last exp %b got %b", expected_bytes[0].last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser[0] !== expected_bytes[0].pend) begin
                    $error("copy_pending exp %b got %b", expected_bytes[0].pend,
                           m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== expected_bytes[0].ovf) begin
                    $error("overflow exp %b got %b", expected_bytes[0].ovf, m_axis_tuser[1]);
                    errors++;
                end
                void'(expected_bytes.pop_front());
            end
            sink_stall <= sink_quiet ? 0 : $urandom_range(0, 8);
            m_axis_tready <= sink_quiet;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= 1'b0;
        i_cfg_wdata   <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= 2'd0;
        foreach (hist_mem[i]) hist_mem[i] = 8'd0;
        foreach (pos_tab[i]) pos_tab[i] = 0;
        ctx_word = 0;
        out_pos = 0;
        mode = MODE_NORMAL;
        src_pos = 0;
        copy_left = 0;
        hash_bits = 32'(HASH_BITS_RST);
        min_len = 32'(MIN_LEN_RST);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_small_len();
        test_drain_pause();
        write_cfg(CFG_HASH_BITS, 8'd31);
        write_cfg(CFG_MIN_LEN, 8'd255);
        test_random_block(150);
        write_cfg(CFG_HASH_BITS, 8'd10);
        write_cfg(CFG_MIN_LEN, 8'd4);
        test_random_block(150);
        write_cfg(CFG_HASH_BITS, 8'($urandom_range(11, 15)));
        write_cfg(CFG_MIN_LEN, 8'($urandom_range(1, 255)));
        test_random_block(150);
        test_overflow();
        write_cfg(CFG_MIN_LEN, 8'd7);
        test_random_block(60);

        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
